@@ hdl/irc_line_tokenizer_assert.svh @@
// Assertion macros for the line tokenizer.
// Define ASSERT_OFF to compile the checks away.
`ifndef IRC_LINE_TOKENIZER_ASSERT_SVH
`define IRC_LINE_TOKENIZER_ASSERT_SVH
`ifndef ASSERT_OFF
// Check a property at every rising clock edge outside reset.
`define ITL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that an expression never holds outside reset.
`define ITL_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ITL_ASSERT(label, clk, rst, prop, msg)
`define ITL_NEVER(label, clk, rst, expr, msg)
`endif
`endif

@@ hdl/itl_pkg.sv @@
`default_nettype none
package itl_pkg;

   localparam int HOLD_DEPTH_DEF = 32;
   localparam int PARAM_LIMIT    = 15;
   localparam logic [3:0] IDX_CAP = (PARAM_LIMIT < 15) ? 4'(PARAM_LIMIT) : 4'd15;
   localparam int QUEUE_DEPTH    = 4;

   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   typedef enum logic [2:0] {
      PH_START,
      PH_PREFIX,
      PH_PRECMD,
      PH_CMD,
      PH_SEP,
      PH_MID,
      PH_TRAIL
   } phase_type;

   typedef enum logic [2:0] {
      K_PREFIX,
      K_CMD,
      K_MID,
      K_TRAIL,
      K_END
   } kind_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_FLUSH,
      BK_EMIT,
      BK_END
   } back_state_type;

   // One classified item, as handed from front to back.
   typedef struct packed {
      logic        do_flush;
      logic        flush_ovf;
      logic        do_hold;
      logic        do_emit;
      kind_type    kind;
      logic [7:0]  data;
      logic        first;
      logic        empty;
      logic [3:0]  pidx;
      logic        do_end;
      logic        msg_void;
   } cmd_type;

endpackage
`default_nettype wire

@@ hdl/itl_front.sv @@
`default_nettype none
module itl_front
   import itl_pkg::*;
#(
   parameter int HOLD_DEPTH = HOLD_DEPTH_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // data_byte[7:0]
   input  wire logic       req_tuser,   // has_byte[0]
   input  wire logic       req_tlast,   // line_end
   input  wire logic       q_full,
   output logic            push,
   output cmd_type         push_cmd
);

   localparam int CW = $clog2(HOLD_DEPTH + 1);

   phase_type       phase_ff, phase_in;
   logic [3:0]      pcount_ff, pcount_in;
   logic            content_ff, content_in;
   logic            prefix_ff, prefix_in;
   logic            started_ff, started_in;
   logic [CW-1:0]   fcnt_ff, fcnt_in;

   logic            accept;
   logic            ws;
   logic [7:0]      upper;
   cmd_type         cmd;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   assign ws    = (req_tdata == CHAR_SPACE) || (req_tdata >= 8'h09 && req_tdata <= 8'h0D);
   assign upper = (req_tdata >= 8'h61 && req_tdata <= 8'h7A) ? req_tdata - 8'h20 : req_tdata;

   always_comb begin
      phase_in   = phase_ff;
      pcount_in  = pcount_ff;
      content_in = content_ff;
      prefix_in  = prefix_ff;
      started_in = started_ff;
      fcnt_in    = fcnt_ff;
      cmd        = '0;
      cmd.kind   = K_PREFIX;

      if (req_tuser) begin
         unique case (phase_ff) inside
            PH_START, PH_PRECMD: begin
               if (!ws) begin
                  if (phase_ff == PH_START && req_tdata == CHAR_COLON) begin
                     phase_in   = PH_PREFIX;
                     prefix_in  = 1'b1;
                     started_in = 1'b0;
                  end else begin
                     phase_in   = PH_CMD;
                     content_in = 1'b1;
                     cmd.do_emit = 1'b1;
                     cmd.kind    = K_CMD;
                     cmd.data    = upper;
                     cmd.first   = 1'b1;
                  end
               end
            end
            PH_PREFIX: begin
               cmd.kind = K_PREFIX;
               if (req_tdata == CHAR_SPACE) begin
                  if (!started_ff) begin
                     cmd.do_emit = 1'b1;
                     cmd.first   = 1'b1;
                     cmd.empty   = 1'b1;
                  end
                  phase_in = PH_PRECMD;
               end else begin
                  cmd.do_emit = 1'b1;
                  cmd.data    = req_tdata;
                  cmd.first   = !started_ff;
                  started_in  = 1'b1;
               end
            end
            PH_CMD: begin
               if (ws) begin
                  phase_in = PH_SEP;
               end else begin
                  cmd.do_emit = 1'b1;
                  cmd.kind    = K_CMD;
                  cmd.data    = upper;
               end
            end
            PH_SEP: begin
               if (!ws) begin
                  if (req_tdata == CHAR_COLON) begin
                     phase_in   = PH_TRAIL;
                     started_in = 1'b0;
                     fcnt_in    = '0;
                  end else begin
                     phase_in    = PH_MID;
                     cmd.do_emit = 1'b1;
                     cmd.kind    = K_MID;
                     cmd.data    = req_tdata;
                     cmd.first   = 1'b1;
                     cmd.pidx    = pcount_ff;
                  end
               end
            end
            PH_MID: begin
               if (ws) begin
                  phase_in = PH_SEP;
                  if (pcount_ff < IDX_CAP) begin
                     pcount_in = pcount_ff + 4'd1;
                  end
               end else begin
                  cmd.do_emit = 1'b1;
                  cmd.kind    = K_MID;
                  cmd.data    = req_tdata;
                  cmd.pidx    = pcount_ff;
               end
            end
            PH_TRAIL: begin
               cmd.kind = K_TRAIL;
               cmd.data = req_tdata;
               cmd.pidx = pcount_ff;
               if (ws) begin
                  if (!req_tlast) begin
                     cmd.do_hold = 1'b1;
                     if (fcnt_ff == CW'(HOLD_DEPTH)) begin
                        cmd.do_flush  = 1'b1;
                        cmd.flush_ovf = 1'b1;
                        cmd.first     = !started_ff;
                        started_in    = 1'b1;
                        fcnt_in       = CW'(1);
                     end else begin
                        fcnt_in = fcnt_ff + CW'(1);
                     end
                  end
               end else begin
                  cmd.do_flush = 1'b1;
                  cmd.do_emit  = 1'b1;
                  cmd.first    = !started_ff;
                  started_in   = 1'b1;
                  fcnt_in      = '0;
               end
            end
            default: begin
               phase_in = PH_START;
            end
         endcase
      end

      if (req_tlast) begin
         cmd.do_end   = 1'b1;
         cmd.msg_void = (phase_in == PH_START) || (phase_in == PH_PREFIX) ||
                        (prefix_in && !content_in);
         if (phase_in == PH_TRAIL && !started_in) begin
            cmd.do_emit = 1'b1;
            cmd.kind    = K_TRAIL;
            cmd.data    = '0;
            cmd.first   = 1'b1;
            cmd.empty   = 1'b1;
            cmd.pidx    = pcount_in;
         end
         phase_in   = PH_START;
         pcount_in  = '0;
         content_in = 1'b0;
         prefix_in  = 1'b0;
         started_in = 1'b0;
         fcnt_in    = '0;
      end
   end

   assign push     = accept && (cmd.do_hold || cmd.do_emit || cmd.do_end || cmd.do_flush);
   assign push_cmd = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_START;
         pcount_ff  <= '0;
         content_ff <= 1'b0;
         prefix_ff  <= 1'b0;
         started_ff <= 1'b0;
         fcnt_ff    <= '0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         pcount_ff  <= pcount_in;
         content_ff <= content_in;
         prefix_ff  <= prefix_in;
         started_ff <= started_in;
         fcnt_ff    <= fcnt_in;
      end
   end

endmodule
`default_nettype wire

@@ hdl/itl_queue.sv @@
`default_nettype none
module itl_queue
   import itl_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   output logic         full,
   output logic         head_valid,
   output cmd_type      head,
   input  wire logic    pop
);

   localparam int PW = $clog2(QUEUE_DEPTH);

   cmd_type          entry_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == (PW+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff + (PW+1)'(do_push) - (PW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

@@ hdl/itl_back.sv @@
`default_nettype none
`include "irc_line_tokenizer_assert.svh"
module itl_back
   import itl_pkg::*;
#(
   parameter int HOLD_DEPTH = HOLD_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        head_valid,
   input  wire cmd_type     head,
   output logic             pop,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,  // out_byte[7:0], token_first, token_empty,
                                        // param_index[3:0], message_void, overflow
   output logic [2:0]       rsp_tuser,  // token_kind[2:0]
   output logic             rsp_tlast   // last_result
);

   localparam int CW = $clog2(HOLD_DEPTH + 1);
   localparam int AW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;

   back_state_type  state_ff, state_in;
   cmd_type         cmd_ff, cmd_in;
   logic [CW-1:0]   idx_ff, idx_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            lead_ff, lead_in;

   logic [7:0]      mem_ff [HOLD_DEPTH];
   logic [7:0]      rd_data_ff;
   logic [AW-1:0]   rd_addr_in;
   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   logic [7:0]      wr_data;

   logic            rsp_valid_ff;
   kind_type        rsp_kind_ff, res_kind;
   logic [7:0]      rsp_byte_ff, res_byte;
   logic            rsp_first_ff, res_first;
   logic            rsp_empty_ff, res_empty;
   logic [3:0]      rsp_pidx_ff, res_pidx;
   logic            rsp_void_ff, res_void;
   logic            rsp_ovf_ff, res_ovf;
   logic            rsp_last_ff, res_last;
   logic            issue;
   logic            out_free;
   logic            flush_done;
   back_state_type  after_flush;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign flush_done = (idx_ff == cnt_ff - CW'(1));
   assign after_flush = cmd_ff.do_emit ? BK_EMIT : (cmd_ff.do_end ? BK_END : BK_IDLE);

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      idx_in     = idx_ff;
      cnt_in     = cnt_ff;
      lead_in    = lead_ff;
      pop        = 1'b0;
      rd_addr_in = '0;
      wr_en      = 1'b0;
      wr_addr    = cnt_ff[AW-1:0];
      wr_data    = head.data;
      issue      = 1'b0;
      res_kind   = cmd_ff.kind;
      res_byte   = cmd_ff.data;
      res_first  = lead_ff && cmd_ff.first;
      res_empty  = 1'b0;
      res_pidx   = cmd_ff.pidx;
      res_void   = 1'b0;
      res_ovf    = 1'b0;
      res_last   = 1'b0;

      unique case (state_ff)
         BK_IDLE: begin
            if (head_valid) begin
               pop = 1'b1;
               if (head.do_hold && !head.do_flush) begin
                  wr_en  = 1'b1;
                  cnt_in = cnt_ff + CW'(1);
               end else begin
                  cmd_in  = head;
                  idx_in  = '0;
                  lead_in = 1'b1;
                  if (head.do_flush && cnt_ff != '0) begin
                     state_in = BK_FLUSH;
                  end else if (head.do_emit) begin
                     state_in = BK_EMIT;
                  end else if (head.do_end) begin
                     state_in = BK_END;
                  end
               end
            end
         end
         BK_FLUSH: begin
            rd_addr_in = idx_ff[AW-1:0];
            if (out_free) begin
               issue    = 1'b1;
               res_kind = K_TRAIL;
               res_byte = rd_data_ff;
               res_ovf  = cmd_ff.flush_ovf;
               res_last = flush_done && !cmd_ff.do_emit && !cmd_ff.do_end;
               lead_in  = 1'b0;
               if (flush_done) begin
                  cnt_in = '0;
                  if (cmd_ff.do_hold) begin
                     wr_en   = 1'b1;
                     wr_addr = '0;
                     wr_data = cmd_ff.data;
                     cnt_in  = CW'(1);
                  end
                  state_in = after_flush;
               end else begin
                  idx_in     = idx_ff + CW'(1);
                  rd_addr_in = AW'(idx_ff + CW'(1));
               end
            end
         end
         BK_EMIT: begin
            if (out_free) begin
               issue     = 1'b1;
               res_empty = cmd_ff.empty;
               res_last  = !cmd_ff.do_end;
               lead_in   = 1'b0;
               state_in  = cmd_ff.do_end ? BK_END : BK_IDLE;
            end
         end
         BK_END: begin
            if (out_free) begin
               issue     = 1'b1;
               res_kind  = K_END;
               res_byte  = '0;
               res_first = 1'b1;
               res_pidx  = '0;
               res_void  = cmd_ff.msg_void;
               res_last  = 1'b1;
               cnt_in    = '0;
               state_in  = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr_in];
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      idx_ff <= idx_in;
      if (issue) begin
         rsp_kind_ff  <= res_kind;
         rsp_byte_ff  <= res_byte;
         rsp_first_ff <= res_first;
         rsp_empty_ff <= res_empty;
         rsp_pidx_ff  <= res_pidx;
         rsp_void_ff  <= res_void;
         rsp_ovf_ff   <= res_ovf;
         rsp_last_ff  <= res_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         cnt_ff       <= '0;
         lead_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         lead_ff  <= lead_in;
         if (issue) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ovf_ff, rsp_void_ff, rsp_pidx_ff, rsp_empty_ff,
                        rsp_first_ff, rsp_byte_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   `ITL_NEVER(a_cnt_bound, clock, reset, (cnt_ff > CW'(HOLD_DEPTH)), "held count above depth")
   `ITL_ASSERT(a_flush_range, clock, reset, ((state_ff == BK_FLUSH) |-> (cnt_ff != '0 && idx_ff < cnt_ff)), "flush index out of range")
   `ITL_ASSERT(a_end_last, clock, reset, ((rsp_valid_ff && rsp_kind_ff == K_END) |-> rsp_last_ff), "end beat not marked last")
   `ITL_ASSERT(a_end_clears, clock, reset, ((state_ff == BK_END && out_free) |=> (cnt_ff == '0)), "held bytes survive end of message")

endmodule
`default_nettype wire

@@ hdl/irc_line_tokenizer.sv @@
`default_nettype none
// Path: a command that yields results passes through the queue into the back-end
// command register, and its results are registered in the output register.
// Throughput: one input beat per cycle while the queue has room; the back end flushes
// a held whitespace run byte by byte through the single read port of the hold memory.
// Reset: synchronous, active high; clears parse state, queue and output valid.
// The hold memory is not cleared and needs no clearing pass.
module irc_line_tokenizer
   import itl_pkg::*;
#(
   parameter int HOLD_DEPTH = HOLD_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // data_byte[7:0]
   input  wire logic        req_tuser,   // has_byte
   input  wire logic        req_tlast,   // line_end
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // out_byte[7:0], token_first, token_empty,
                                         // param_index[3:0], message_void, overflow
   output logic [2:0]       rsp_tuser,   // token_kind[2:0]
   output logic             rsp_tlast    // last_result
);

   // Front: parse each beat into at most one command; back: expand commands into results.
   logic    q_full;
   logic    push;
   cmd_type push_cmd;
   logic    head_valid;
   cmd_type head;
   logic    pop;

   itl_front #(
      .HOLD_DEPTH (HOLD_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   // Short queue lets the parser keep taking beats while results drain.
   itl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop)
   );

   // Back end owns the hold memory and the output register.
   itl_back #(
      .HOLD_DEPTH (HOLD_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

@@ bench/testbench.sv @@
`default_nettype none
module testbench
   import itl_pkg::*;
();

   localparam int RAND_BEATS   = 420;
   localparam int LIMIT_CYCLES = 1_500_000;
   localparam int DRAIN_CYCLES = 40;

   // One result beat, unpacked into its fields.
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data;
      logic        first;
      logic        empty;
      logic [3:0]  pidx;
      logic        msg_void;
      logic        ovf;
      logic        last;
   } token_beat_type;

   // One row of the directed table; typed rows carry their single expected beat.
   typedef struct packed {
      logic           has;
      logic [7:0]     data;
      logic           line_end;
      logic           typed;
      token_beat_type want;
   } dir_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   irc_line_tokenizer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Tokenizer shadow state.
   phase_type   phase;
   logic [7:0]  held_ws [HOLD_DEPTH_DEF];
   int          held_n;
   logic [3:0]  param_no;
   bit          saw_body;
   bit          saw_prefix;
   bit          tok_open;

   token_beat_type beat_toks[$];   // tokens caused by the beat just accepted
   token_beat_type token_q[$];     // tokens still owed by the block
   dir_row_type    dir_tab[$];
   logic [7:0]     line_bytes[$];

   bit          calm;
   int          err_count;
   int          in_beats;
   int          lines_sent;
   int          toks_checked;
   int          ovf_seen;
   int          cap_seen;
   int          cycle_count;

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic bit is_space(logic [7:0] b);
      return (b == CHAR_SPACE) || (b >= 8'h09 && b <= 8'h0D);
   endfunction

   function automatic logic [7:0] upper(logic [7:0] b);
      return (b >= 8'h61 && b <= 8'h7A) ? b - 8'h20 : b;
   endfunction

   function automatic void add_tok(kind_type k, logic [7:0] d, bit first, bit empty,
                                   logic [3:0] pidx, bit vd, bit ov);
      token_beat_type t;
      t.kind = k; t.data = d; t.first = first; t.empty = empty;
      t.pidx = pidx; t.msg_void = vd; t.ovf = ov; t.last = 1'b0;
      beat_toks = {beat_toks, t};
   endfunction

   // Release the held whitespace run as trailing bytes.
   function automatic void release_held(bit ov);
      for (int i = 0; i < held_n; i++) begin
         add_tok(K_TRAIL, held_ws[i], !tok_open, 1'b0, param_no, 1'b0, ov);
         tok_open = 1;
      end
      held_n = 0;
   endfunction

   function automatic void clear_line();
      phase = PH_START;
      held_n = 0;
      param_no = '0;
      saw_body = 0;
      saw_prefix = 0;
      tok_open = 0;
   endfunction

   // Advance the shadow state by one accepted beat and collect its tokens.
   function automatic void tokenize_beat(bit has, logic [7:0] b, bit le);
      bit ws;
      bit vd;
      ws = is_space(b);
      beat_toks.delete();
      if (has) begin
         case (phase) inside
            PH_START, PH_PRECMD: begin
               if (!ws) begin
                  if (phase == PH_START && b == CHAR_COLON) begin
                     phase = PH_PREFIX;
                     saw_prefix = 1;
                     tok_open = 0;
                  end else begin
                     phase = PH_CMD;
                     saw_body = 1;
                     add_tok(K_CMD, upper(b), 1'b1, 1'b0, 4'd0, 1'b0, 1'b0);
                  end
               end
            end
            PH_PREFIX: begin
               // only a real space closes the prefix; tabs and the like are kept
               if (b == CHAR_SPACE) begin
                  if (!tok_open) add_tok(K_PREFIX, 8'h00, 1'b1, 1'b1, 4'd0, 1'b0, 1'b0);
                  phase = PH_PRECMD;
               end else begin
                  add_tok(K_PREFIX, b, !tok_open, 1'b0, 4'd0, 1'b0, 1'b0);
                  tok_open = 1;
               end
            end
            PH_CMD: begin
               if (ws) phase = PH_SEP;
               else add_tok(K_CMD, upper(b), 1'b0, 1'b0, 4'd0, 1'b0, 1'b0);
            end
            PH_SEP: begin
               if (!ws) begin
                  if (b == CHAR_COLON) begin
                     phase = PH_TRAIL;
                     tok_open = 0;
                     held_n = 0;
                  end else begin
                     phase = PH_MID;
                     add_tok(K_MID, b, 1'b1, 1'b0, param_no, 1'b0, 1'b0);
                  end
               end
            end
            PH_MID: begin
               if (ws) begin
                  phase = PH_SEP;
                  if (param_no < IDX_CAP) param_no = param_no + 4'd1;
               end else begin
                  add_tok(K_MID, b, 1'b0, 1'b0, param_no, 1'b0, 1'b0);
               end
            end
            default: begin
               // trailing: hold whitespace, flush early when the hold is full,
               // and drop whitespace that comes with the line end
               if (ws) begin
                  if (!le) begin
                     if (held_n >= HOLD_DEPTH_DEF) release_held(1'b1);
                     held_ws[held_n] = b;
                     held_n++;
                  end
               end else begin
                  release_held(1'b0);
                  add_tok(K_TRAIL, b, !tok_open, 1'b0, param_no, 1'b0, 1'b0);
                  tok_open = 1;
               end
            end
         endcase
      end
      if (le) begin
         vd = (phase == PH_START) || (phase == PH_PREFIX) || (saw_prefix && !saw_body);
         if (phase == PH_TRAIL && !tok_open)
            add_tok(K_TRAIL, 8'h00, 1'b1, 1'b1, param_no, 1'b0, 1'b0);
         add_tok(K_END, 8'h00, 1'b1, 1'b0, 4'd0, vd, 1'b0);
         clear_line();
      end
      if (beat_toks.size() > 0) beat_toks[beat_toks.size() - 1].last = 1'b1;
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic dir_row_type mk(bit has, logic [7:0] d, bit le);
      dir_row_type r;
      r = '0;
      r.has = has; r.data = d; r.line_end = le;
      return r;
   endfunction

   // Row whose single result is written out by hand.
   function automatic dir_row_type mkt(bit has, logic [7:0] d, bit le, kind_type k,
                                       logic [7:0] od, bit first, bit empty, bit vd);
      dir_row_type r;
      r = mk(has, d, le);
      r.typed = 1'b1;
      r.want.kind = k; r.want.data = od; r.want.first = first; r.want.empty = empty;
      r.want.pidx = 4'd0; r.want.msg_void = vd; r.want.ovf = 1'b0; r.want.last = 1'b1;
      return r;
   endfunction

   // Append one row to the directed table.
   function automatic void add_row(dir_row_type r);
      dir_tab = {dir_tab, r};
   endfunction

   // Append one byte to the line being built.
   function automatic void add_byte(logic [7:0] b);
      line_bytes = {line_bytes, b};
   endfunction

   // Mostly no gap, some short ones, a few long ones; none while calm.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   function automatic logic [7:0] ws_byte();
      if ($urandom_range(0, 1)) return CHAR_SPACE;
      return 8'h09 + 8'($urandom_range(0, 4));
   endfunction

   function automatic logic [7:0] word_byte(bit colon_ok);
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (is_space(b) || (!colon_ok && b == CHAR_COLON));
      return b;
   endfunction

   function automatic void add_ws(int n);
      repeat (n) add_byte(ws_byte());
   endfunction

   function automatic void add_word(int n, bit colon_ok);
      repeat (n) add_byte(word_byte(colon_ok));
   endfunction

   // Drive one beat, hold it until accepted, then predict its tokens.
   task automatic send_beat(bit has, logic [7:0] d, bit le, bit typed,
                            token_beat_type want);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = has;
      req_tdata  = d;
      req_tlast  = le;
      do @(posedge clock); while (!req_tready);
      tokenize_beat(has, d, le);
      if (typed) token_q = {token_q, want};
      else token_q = {token_q, beat_toks};
      if (has || le) in_beats++;
      @(negedge clock);
   endtask

   // Build one random line, mostly well formed, then send it.
   task automatic send_line();
      int shape;
      int n;
      logic [7:0] b;
      bit attach;
      line_bytes.delete();
      calm = ($urandom_range(0, 5) == 0);
      shape = $urandom_range(0, 9);
      if (shape < 7) begin
         if ($urandom_range(0, 3) == 0) add_ws($urandom_range(1, 3));
         if ($urandom_range(0, 2) == 0) begin
            add_byte(CHAR_COLON);
            repeat ($urandom_range(0, 6)) begin
               do b = 8'($urandom_range(0, 255)); while (b == CHAR_SPACE);
               add_byte(b);
            end
            if ($urandom_range(0, 7) != 0) add_byte(CHAR_SPACE);
         end
         if ($urandom_range(0, 9) != 0) begin
            repeat ($urandom_range(1, 5)) begin
               case ($urandom_range(0, 3))
                  0: add_byte(8'h61 + 8'($urandom_range(0, 25)));
                  1: add_byte(8'h41 + 8'($urandom_range(0, 25)));
                  2: add_byte(8'h30 + 8'($urandom_range(0, 9)));
                  default: add_byte(word_byte(1'b0));
               endcase
            end
            // a few lines run past the parameter cap
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 4);
            repeat (n) begin
               add_ws($urandom_range(1, 2));
               add_word($urandom_range(1, 3), 1'b0);
            end
            if ($urandom_range(0, 1)) begin
               add_ws($urandom_range(1, 2));
               add_byte(CHAR_COLON);
               repeat ($urandom_range(0, 4)) begin
                  // long runs can overflow the hold buffer once or twice
                  if ($urandom_range(0, 9) == 0) add_ws($urandom_range(30, 68));
                  else add_ws($urandom_range(0, 3));
                  add_word($urandom_range(1, 4), 1'b1);
               end
               if ($urandom_range(0, 2) == 0) add_ws($urandom_range(1, 5));
            end
         end
      end else if (shape < 9) begin
         repeat ($urandom_range(1, 12)) begin
            case ($urandom_range(0, 3))
               0: add_byte(CHAR_COLON);
               1: add_byte(CHAR_SPACE);
               default: add_byte(8'($urandom_range(0, 255)));
            endcase
         end
      end else begin
         // broken fragments: colons and whitespace only
         repeat ($urandom_range(1, 8)) begin
            if ($urandom_range(0, 2) == 0) add_byte(CHAR_COLON);
            else add_byte(ws_byte());
         end
      end
      attach = (line_bytes.size() > 0) && ($urandom_range(0, 1) == 1);
      foreach (line_bytes[i]) begin
         if ($urandom_range(0, 19) == 0) send_beat(1'b0, 8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
         send_beat(1'b1, line_bytes[i], attach && (i == line_bytes.size() - 1), 1'b0, '0);
      end
      if (!attach) send_beat(1'b0, 8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
      lines_sent++;
   endtask

   // ---------------------------------------------------------------- receiver

   initial begin
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else begin
            rsp_tready = 1'b1;
            if ($urandom_range(0, 2) == 0) stall_left = pick_gap();
         end
      end
   end

   function automatic string tok_str(token_beat_type t);
      return $sformatf("kind=%0d byte=%02h first=%0b empty=%0b pidx=%0d void=%0b ovf=%0b last=%0b",
                       t.kind, t.data, t.first, t.empty, t.pidx, t.msg_void, t.ovf, t.last);
   endfunction

   // Compare every accepted result beat with the oldest owed token.
   always @(posedge clock) begin
      token_beat_type got;
      token_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind     = kind_type'(rsp_tuser);
         got.data     = rsp_tdata[7:0];
         got.first    = rsp_tdata[8];
         got.empty    = rsp_tdata[9];
         got.pidx     = rsp_tdata[13:10];
         got.msg_void = rsp_tdata[14];
         got.ovf      = rsp_tdata[15];
         got.last     = rsp_tlast;
         if (token_q.size() == 0) begin
            err_count++;
            if (err_count <= 40)
               $display("%0t: unexpected result beat: expected none, got %s",
                        $time, tok_str(got));
         end else begin
            want = token_q.pop_front();
            toks_checked++;
            if (want.ovf) ovf_seen++;
            if ((want.kind == K_MID || want.kind == K_TRAIL) && want.pidx == IDX_CAP) cap_seen++;
            if (got.kind !== want.kind || got.data !== want.data ||
                got.first !== want.first || got.empty !== want.empty ||
                got.pidx !== want.pidx || got.msg_void !== want.msg_void ||
                got.ovf !== want.ovf || got.last !== want.last) begin
               err_count++;
               if (err_count <= 40)
                  $display("%0t: token mismatch: expected %s, got %s",
                           $time, tok_str(want), tok_str(got));
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("%0t: timeout with %0d tokens still owed", $time, token_q.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // ---------------------------------------------------------------- main flow

   initial begin
      req_tvalid = 1'b0;
      req_tdata  = 8'h00;
      req_tuser  = 1'b0;
      req_tlast  = 1'b0;
      reset      = 1'b1;
      calm       = 0;
      err_count  = 0;
      in_beats   = 0;
      lines_sent = 0;
      toks_checked = 0;
      ovf_seen   = 0;
      cap_seen   = 0;
      cycle_count = 0;
      clear_line();

      // bare line end right after reset: empty message
      add_row(mkt(1'b0, 8'h00, 1'b1, K_END, 8'h00, 1'b1, 1'b0, 1'b1));
      // colon then space: empty prefix, then a lower-case command
      add_row(mk(1'b1, ":", 1'b0));
      add_row(mkt(1'b1, " ", 1'b0, K_PREFIX, 8'h00, 1'b1, 1'b1, 1'b0));
      add_row(mkt(1'b1, "q", 1'b0, K_CMD, "Q", 1'b1, 1'b0, 1'b0));
      add_row(mk(1'b1, 8'h0B, 1'b0));
      add_row(mkt(1'b1, 8'hFF, 1'b0, K_MID, 8'hFF, 1'b1, 1'b0, 1'b0));
      add_row(mk(1'b1, " ", 1'b0));
      add_row(mk(1'b1, 8'h00, 1'b0));
      add_row(mk(1'b1, 8'h09, 1'b0));
      // trailing with a held run released by a later byte
      add_row(mk(1'b1, ":", 1'b0));
      add_row(mk(1'b1, " ", 1'b0));
      add_row(mk(1'b1, 8'h0D, 1'b0));
      add_row(mk(1'b1, "x", 1'b0));
      add_row(mk(1'b1, " ", 1'b0));
      // whitespace at the line end is trimmed
      add_row(mkt(1'b1, 8'h0C, 1'b1, K_END, 8'h00, 1'b1, 1'b0, 1'b0));
      // prefix that no space closes: void
      add_row(mk(1'b1, ":", 1'b0));
      add_row(mk(1'b1, "n", 1'b0));
      add_row(mk(1'b1, "k", 1'b1));
      // idle beat with junk data
      add_row(mk(1'b0, 8'hA5, 1'b0));
      // empty trailing closed by a bare end marker
      add_row(mk(1'b1, "z", 1'b0));
      add_row(mk(1'b1, " ", 1'b0));
      add_row(mk(1'b1, ":", 1'b0));
      add_row(mk(1'b0, 8'h5A, 1'b1));
      // whitespace-only line
      add_row(mkt(1'b1, 8'h20, 1'b1, K_END, 8'h00, 1'b1, 1'b0, 1'b1));
      // only whitespace after the prefix: void
      add_row(mk(1'b1, ":", 1'b0));
      add_row(mk(1'b1, "a", 1'b0));
      add_row(mk(1'b1, " ", 1'b0));
      add_row(mkt(1'b1, 8'h09, 1'b1, K_END, 8'h00, 1'b1, 1'b0, 1'b1));

      // hold reset, then release it on a falling edge
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_tab[i])
         send_beat(dir_tab[i].has, dir_tab[i].data, dir_tab[i].line_end,
                   dir_tab[i].typed, dir_tab[i].want);
      n_random: while (in_beats < dir_tab.size() + RAND_BEATS) send_line();
      req_tvalid = 1'b0;

      // drain the owed tokens, then idle a while to catch strays
      while (token_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d input beats (%0d random lines), %0d result beats checked",
               in_beats, lines_sent, toks_checked);
      $display("%0d early-flushed hold beats, %0d beats at the parameter cap",
               ovf_seen, cap_seen);
      if (err_count == 0 && token_q.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
`default_nettype wire
